### sv/txrr_pkg.sv
// Shared constants, codes and controller/datapath interface types for the ring dispatcher.
package txrr_pkg;

   localparam int CHANNELS     = 8;
   localparam int RING_SLOTS   = 16;
   localparam int MAX_DISPATCH = 8;

   localparam int OP_W   = 2;
   localparam int KIND_W = 2;
   localparam int CH_W   = 3;
   localparam int SLOT_W = 4;
   localparam int RING_W = $clog2(RING_SLOTS);
   localparam int CIDX_W = $clog2(CHANNELS);
   localparam int NCNT_W = $clog2(MAX_DISPATCH + 1);
   localparam int CMP_W  = (RING_W > SLOT_W) ? RING_W : SLOT_W;

   localparam logic [OP_W-1:0] OP_STAGE   = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_SETUP   = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SETUP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS   = 2'd2;

   typedef struct packed {
      logic load;
      logic apply;
      logic emit_single;
      logic emit_dispatch;
      logic emit_status;
   } cmd_type;

   typedef struct packed {
      logic single_op;
      logic found;
      logic out_free;
   } stat_type;

endpackage

### sv/txrr_ctrl.sv
// Dispatcher sequencer: accept, apply, one result per cycle unless stalled.
module txrr_ctrl import txrr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_APPLY = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [NCNT_W-1:0] ndisp_ff, ndisp_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ndisp_in = ndisp_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (stat.single_op) begin
               if (stat.out_free) begin
                  cmd.emit_single = 1'b1;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.apply = 1'b1;
               ndisp_in  = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.out_free) begin
               if (stat.found && (int'(ndisp_ff) < MAX_DISPATCH)) begin
                  cmd.emit_dispatch = 1'b1;
                  ndisp_in          = ndisp_ff + 1'b1;
               end else begin
                  cmd.emit_status = 1'b1;
                  state_in        = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ndisp_ff <= '0;
      end else begin
         state_ff <= state_in;
         ndisp_ff <= ndisp_in;
      end
   end

endmodule

### sv/txrr_datapath.sv
// Ring pointers, staged packet table, round-robin pick and the result register.
module txrr_datapath import txrr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [OP_W-1:0]   req_op,
   input  logic [CH_W-1:0]   req_ch,
   input  logic [SLOT_W-1:0] req_cnt,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [CH_W-1:0]   rsp_chan,
   output logic [SLOT_W-1:0] rsp_first,
   output logic [SLOT_W-1:0] rsp_taken,
   output logic [SLOT_W-1:0] rsp_free,
   output logic              rsp_rej,
   output logic              rsp_last
);

   logic [OP_W-1:0]   op_ff;
   logic [CH_W-1:0]   ch_ff;
   logic [SLOT_W-1:0] cnt_ff;
   logic              rej_ff, rej_in;

   logic [SLOT_W-1:0] staged_ff [CHANNELS];
   logic [SLOT_W-1:0] staged_in [CHANNELS];
   logic [RING_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CIDX_W-1:0] last_ff, last_in;

   logic              out_valid_ff;
   logic [KIND_W-1:0] kind_ff, kind_n;
   logic [CH_W-1:0]   chan_ff, chan_n;
   logic [SLOT_W-1:0] first_ff, first_n, taken_ff, taken_n, freeo_ff, freeo_n;
   logic              orej_ff, orej_n, olast_ff, olast_n;

   logic [RING_W-1:0] used, free;
   logic [CHANNELS-1:0] fit;
   logic [CIDX_W-1:0] pick;
   logic              found;
   logic [SLOT_W-1:0] pick_need;
   logic              out_free;
   logic              emit_any;

   assign used     = head_ff - tail_ff;
   assign free     = RING_W'(RING_SLOTS - 1) - used;
   assign out_free = !out_valid_ff || rsp_tready;
   assign emit_any = cmd.emit_single || cmd.emit_dispatch || cmd.emit_status;

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         fit[i] = (staged_ff[i] != '0) && (CMP_W'(staged_ff[i]) <= CMP_W'(free));
      end
   end

   // Lowest rotated offset from the channel after the last one served wins.
   always_comb begin
      int s;
      int idx;
      s = int'(last_ff) + 1;
      if (s >= CHANNELS) s = 0;
      pick  = '0;
      found = 1'b0;
      for (int k = CHANNELS - 1; k >= 0; k--) begin
         idx = s + k;
         if (idx >= CHANNELS) idx = idx - CHANNELS;
         if (fit[CIDX_W'(idx)]) begin
            pick  = CIDX_W'(idx);
            found = 1'b1;
         end
      end
   end

   assign pick_need = staged_ff[pick];

   assign stat.single_op = (op_ff == OP_SETUP) || (op_ff == OP_UNUSED);
   assign stat.found     = found;
   assign stat.out_free  = out_free;

   // Next state of the ring and table.
   always_comb begin
      logic [CMP_W-1:0] rel;
      rel     = CMP_W'(cnt_ff);
      rej_in  = rej_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      last_in = last_ff;
      for (int i = 0; i < CHANNELS; i++) staged_in[i] = staged_ff[i];
      if (cmd.apply) begin
         rej_in = 1'b0;
         if (op_ff == OP_STAGE) begin
            if ((int'(ch_ff) >= CHANNELS) || (cnt_ff == '0) ||
                (int'(cnt_ff) > RING_SLOTS - 1) ||
                (staged_ff[ch_ff[CIDX_W-1:0]] != '0)) begin
               rej_in = 1'b1;
            end else begin
               staged_in[ch_ff[CIDX_W-1:0]] = cnt_ff;
            end
         end else begin
            if (rel > CMP_W'(used)) begin
               rel    = CMP_W'(used);
               rej_in = 1'b1;
            end
            tail_in = tail_ff + RING_W'(rel);
         end
      end
      if (cmd.emit_single && (op_ff == OP_SETUP) && (free != '0)) begin
         head_in = head_ff + 1'b1;
      end
      if (cmd.emit_dispatch) begin
         head_in         = head_ff + RING_W'(pick_need);
         last_in         = pick;
         staged_in[pick] = '0;
      end
   end

   // Result fields; free count is the value after this result.
   always_comb begin
      kind_n  = KIND_STATUS;
      chan_n  = '0;
      first_n = '0;
      taken_n = '0;
      freeo_n = SLOT_W'(free);
      orej_n  = rej_ff;
      olast_n = 1'b1;
      if (cmd.emit_single) begin
         if ((op_ff == OP_SETUP) && (free != '0)) begin
            kind_n  = KIND_SETUP;
            first_n = SLOT_W'(head_ff);
            taken_n = SLOT_W'(1);
            freeo_n = SLOT_W'(free - 1'b1);
            orej_n  = 1'b0;
         end else begin
            orej_n = 1'b1;
         end
      end else if (cmd.emit_dispatch) begin
         kind_n  = KIND_DISPATCH;
         chan_n  = CH_W'(pick);
         first_n = SLOT_W'(head_ff);
         taken_n = pick_need;
         freeo_n = SLOT_W'(free - RING_W'(pick_need));
         orej_n  = 1'b0;
         olast_n = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         ch_ff  <= req_ch;
         cnt_ff <= req_cnt;
      end
      if (emit_any) begin
         kind_ff  <= kind_n;
         chan_ff  <= chan_n;
         first_ff <= first_n;
         taken_ff <= taken_n;
         freeo_ff <= freeo_n;
         orej_ff  <= orej_n;
         olast_ff <= olast_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) staged_ff[i] <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         last_ff      <= '0;
         rej_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < CHANNELS; i++) staged_ff[i] <= staged_in[i];
         head_ff <= head_in;
         tail_ff <= tail_in;
         last_ff <= last_in;
         rej_ff  <= rej_in;
         if (emit_any)        out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_chan   = chan_ff;
   assign rsp_first  = first_ff;
   assign rsp_taken  = taken_ff;
   assign rsp_free   = freeo_ff;
   assign rsp_rej    = orej_ff;
   assign rsp_last   = olast_ff;

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      emit_any |-> out_free)
      else $error("result loaded while the output register is still held");

   a_dispatch_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (kind_ff == KIND_DISPATCH)) |-> (taken_ff != '0) && !orej_ff && !olast_ff)
      else $error("dispatch result with bad fields");

   a_final_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (kind_ff != KIND_DISPATCH)) |-> olast_ff)
      else $error("setup or status result without last");

   a_served_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_dispatch |=> (staged_ff[$past(pick)] == '0) && (last_ff == $past(pick)))
      else $error("served channel still staged");

endmodule

### sv/tx_ring_round_robin_dispatch_core.sv
// Top level of the round-robin transmit dispatcher over a descriptor ring.
//
// Input channel (req_): one item per command. req_tuser carries the opcode
// (stage packet, release descriptors, queue setup frame); req_tdata carries
// the channel and the descriptor count.
// Result channel (rsp_): a stage or release item yields zero or more dispatch
// items, one per packet sent, followed by a status item with rsp_tlast high.
// A setup item yields exactly one item (setup queued, or status if full).
// Sequencing: an item is taken in S_IDLE and applied in S_APPLY, and then
// one result per cycle is loaded into the output register while it is free,
// so a stage or release yields at most eight dispatches before its status;
// a setup or unused item loads its one result from S_APPLY. Each dispatch is
// a step of its own because every pick re-checks all channels against the
// free count left by the previous pick.
// The block takes one item at a time; req_tready is high while it waits for
// work, even if the last result has not been taken yet.
// When the receiver stalls, the result register holds and the sequencer
// waits; nothing is dropped. Reset empties the ring, clears every staged
// packet and restarts the round-robin order after channel 0.
module tx_ring_round_robin_dispatch_core import txrr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // channel[2:0], count[6:3], zero pad
   input  logic [OP_W-1:0]     req_tuser,   // opcode[1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // served_channel[2:0], first_slot[6:3],
                                            // slots_taken[10:7], free_slots[14:11],
                                            // rejected[15]
   output logic [KIND_W-1:0]   rsp_tuser,   // kind[1:0]
   output logic                rsp_tlast
);

   cmd_type  cmd;
   stat_type stat;

   logic [CH_W-1:0]   rsp_chan;
   logic [SLOT_W-1:0] rsp_first, rsp_taken, rsp_free;
   logic              rsp_rej;

   txrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   txrr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_tuser),
      .req_ch     (req_tdata[2:0]),
      .req_cnt    (req_tdata[6:3]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_chan   (rsp_chan),
      .rsp_first  (rsp_first),
      .rsp_taken  (rsp_taken),
      .rsp_free   (rsp_free),
      .rsp_rej    (rsp_rej),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {rsp_rej, rsp_free, rsp_taken, rsp_first, rsp_chan};

endmodule

### sim/txrr_dispatch_checker.sv
// Scoreboard for the ring dispatcher: predicts each item's results and checks the rsp stream.
module txrr_dispatch_checker import txrr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [7:0]        req_tdata,   // channel[2:0], count[6:3], zero pad
   input  logic [OP_W-1:0]   req_tuser,   // opcode[1:0]
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [15:0]       rsp_tdata,   // served_channel, first_slot, slots_taken,
                                          // free_slots, rejected
   input  logic [KIND_W-1:0] rsp_tuser,   // kind[1:0]
   input  logic              rsp_tlast,
   output int                fail_count,
   output int                pending,
   output int                dispatch_count,
   output int                reject_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CH_W-1:0]   chan;
      logic [SLOT_W-1:0] first;
      logic [SLOT_W-1:0] taken;
      logic [SLOT_W-1:0] free;
      logic              rej;
      logic              last;
   } ring_result_type;

   // shadow of the scheduler state
   logic [SLOT_W-1:0] chan_need [CHANNELS];
   logic [RING_W-1:0] fill_ptr;
   logic [RING_W-1:0] drain_ptr;
   logic [CIDX_W-1:0] rr_last;
   ring_result_type   expected_results [$];

   // one slot always stays empty
   function automatic int free_now();
      return RING_SLOTS - 1 - ((int'(fill_ptr) + RING_SLOTS - int'(drain_ptr)) % RING_SLOTS);
   endfunction

   function automatic void queue_result(logic [KIND_W-1:0] kind, logic [CH_W-1:0] chan,
                                        logic [SLOT_W-1:0] first, logic [SLOT_W-1:0] taken,
                                        logic rej, logic last);
      ring_result_type r;
      r.kind  = kind;
      r.chan  = chan;
      r.first = first;
      r.taken = taken;
      r.free  = SLOT_W'(free_now());
      r.rej   = rej;
      r.last  = last;
      expected_results.push_back(r);
   endfunction

   function automatic string show(ring_result_type r);
      return $sformatf("kind %0d ch %0d first %0d taken %0d free %0d rej %0d last %0d",
                       r.kind, r.chan, r.first, r.taken, r.free, r.rej, r.last);
   endfunction

   function automatic void predict_dispatch(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                            logic [SLOT_W-1:0] cnt);
      logic rej;
      int   used;
      int   give_back;
      int   n;
      int   idx;
      int   pick;
      bit   done;
      rej  = 1'b0;
      n    = 0;
      done = 1'b0;
      if (op == OP_SETUP) begin
         if (free_now() == 0) begin
            queue_result(KIND_STATUS, '0, '0, '0, 1'b1, 1'b1);
         end else begin
            idx = int'(fill_ptr);
            fill_ptr = RING_W'((idx + 1) % RING_SLOTS);
            queue_result(KIND_SETUP, '0, SLOT_W'(idx), SLOT_W'(1), 1'b0, 1'b1);
         end
         return;
      end
      if (op == OP_UNUSED) begin
         queue_result(KIND_STATUS, '0, '0, '0, 1'b1, 1'b1);
         return;
      end
      if (op == OP_STAGE) begin
         if (int'(ch) >= CHANNELS || cnt == '0 || int'(cnt) > RING_SLOTS - 1 ||
             chan_need[ch] != '0) begin
            rej = 1'b1;
         end else begin
            chan_need[ch] = cnt;
         end
      end else begin
         // release is cut to what is in use
         used = RING_SLOTS - 1 - free_now();
         give_back = int'(cnt);
         if (give_back > used) begin
            give_back = used;
            rej = 1'b1;
         end
         drain_ptr = RING_W'((int'(drain_ptr) + give_back) % RING_SLOTS);
      end
      // each pass serves the first channel after the last served that fits
      while (n < MAX_DISPATCH && !done) begin
         pick = -1;
         for (int s = 1; s <= CHANNELS; s++) begin
            idx = (int'(rr_last) + s) % CHANNELS;
            if (pick < 0 && chan_need[CIDX_W'(idx)] != '0 &&
                int'(chan_need[CIDX_W'(idx)]) <= free_now())
               pick = idx;
         end
         if (pick < 0) begin
            done = 1'b1;
         end else begin
            idx = int'(fill_ptr);
            fill_ptr = RING_W'((idx + int'(chan_need[CIDX_W'(pick)])) % RING_SLOTS);
            rr_last = CIDX_W'(pick);
            queue_result(KIND_DISPATCH, CH_W'(pick), SLOT_W'(idx), chan_need[CIDX_W'(pick)],
                         1'b0, 1'b0);
            chan_need[CIDX_W'(pick)] = '0;
            n++;
         end
      end
      queue_result(KIND_STATUS, '0, '0, '0, rej, 1'b1);
   endfunction

   always @(posedge clock) begin
      ring_result_type got;
      ring_result_type want;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) chan_need[c] = '0;
         fill_ptr = '0;
         drain_ptr = '0;
         rr_last = '0;
         expected_results.delete();
         pending = 0;
         fail_count = 0;
         dispatch_count = 0;
         reject_count = 0;
      end else begin
         // results first: one accepted at this edge belongs to an earlier item
         if (rsp_tvalid && rsp_tready) begin
            got.kind  = rsp_tuser;
            got.chan  = rsp_tdata[2:0];
            got.first = rsp_tdata[6:3];
            got.taken = rsp_tdata[10:7];
            got.free  = rsp_tdata[14:11];
            got.rej   = rsp_tdata[15];
            got.last  = rsp_tlast;
            if (got.kind == KIND_DISPATCH) dispatch_count++;
            if (got.rej) reject_count++;
            if (expected_results.size() == 0) begin
               if (fail_count < 10) $display("%t unexpected result: %s", $realtime, show(got));
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.kind !== want.kind || got.chan !== want.chan ||
                   got.first !== want.first || got.taken !== want.taken ||
                   got.free !== want.free || got.rej !== want.rej ||
                   got.last !== want.last) begin
                  if (fail_count < 10) begin
                     $display("%t mismatch  expected: %s", $realtime, show(want));
                     $display("%t           actual:   %s", $realtime, show(got));
                  end
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_dispatch(req_tuser, req_tdata[2:0], req_tdata[6:3]);
         pending = expected_results.size();
      end
   end

endmodule

### sim/tb_tx_ring_round_robin_dispatch_core.sv
// Testbench top for the ring dispatcher: clock, reset, item stimulus, output stalls, verdict.
module tb_tx_ring_round_robin_dispatch_core;
   import txrr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 150;   // long output stall, enough to back up the input

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [7:0]        req_tdata;      // channel[2:0], count[6:3], zero pad
   logic [OP_W-1:0]   req_tuser;      // opcode[1:0]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [15:0]       rsp_tdata;      // served_channel[2:0], first_slot[6:3],
                                      // slots_taken[10:7], free_slots[14:11], rejected[15]
   logic [KIND_W-1:0] rsp_tuser;      // kind[1:0]
   logic              rsp_tlast;

   int fail_count;
   int pending;
   int dispatch_count;
   int reject_count;
   int items_sent = 0;

   // handshake between the two driving processes
   bit sender_gaps = 1'b1;   // sender may insert idle bursts
   bit calm        = 1'b0;   // final stretch: no idling on either side
   bit hold_start  = 1'b0;   // asks the receiver for one long stall

   tx_ring_round_robin_dispatch_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   txrr_dispatch_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .pending        (pending),
      .dispatch_count (dispatch_count),
      .reject_count   (reject_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offer one item and hold it until accepted. Called at a rising edge; returns at
   // the edge of acceptance, or after an idle burst with tvalid low.
   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                           input logic [SLOT_W-1:0] cnt);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, cnt, ch};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (sender_gaps && !calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Mostly well-formed traffic: small stages that fit, modest releases, some setups.
   // Wide counts and the unused opcode show up now and then.
   task automatic send_random();
      int pick;
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] cnt;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         op  = OP_STAGE;
         cnt = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(0, 15))
                                          : SLOT_W'($urandom_range(1, 5));
      end else if (pick < 80) begin
         op  = OP_RELEASE;
         cnt = ($urandom_range(0, 5) == 0) ? SLOT_W'($urandom_range(0, 15))
                                          : SLOT_W'($urandom_range(0, 8));
      end else if (pick < 96) begin
         op  = OP_SETUP;
         cnt = SLOT_W'($urandom_range(0, 15));
      end else begin
         op  = OP_UNUSED;
         cnt = SLOT_W'($urandom_range(0, 15));
      end
      send_cmd(op, CH_W'($urandom_range(0, 7)), cnt);
   endtask

   // Drop tvalid and wait for every expected result. The pending count is read at
   // the falling edge so that the checker has already handled the rising one.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Sender: reset, directed cases, back-pressure burst, random traffic, verdict.
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_STAGE;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, ring starts empty with 15 free slots
      send_cmd(OP_STAGE, 3'd0, 4'd0);      // stage of zero is refused
      send_cmd(OP_STAGE, 3'd0, 4'd15);     // largest packet fits an empty ring exactly
      send_cmd(OP_SETUP, 3'd0, 4'd0);      // ring full: setup refused
      send_cmd(OP_UNUSED, 3'd7, 4'd15);    // unused opcode, status only
      for (int c = 1; c < CHANNELS; c++)   // every other channel waits on a full ring
         send_cmd(OP_STAGE, CH_W'(c), 4'd1);
      send_cmd(OP_STAGE, 3'd3, 4'd2);      // channel already holds a packet
      send_cmd(OP_STAGE, 3'd0, 4'd1);      // all eight channels now staged
      send_cmd(OP_RELEASE, 3'd0, 4'd15);   // frees the ring: eight dispatches, the cap
      send_cmd(OP_RELEASE, 3'd5, 4'd15);   // more than in use: saturates
      send_cmd(OP_SETUP, 3'd2, 4'd9);      // setup frame takes one slot
      send_cmd(OP_STAGE, 3'd7, 4'd15);     // one short of fitting
      send_cmd(OP_RELEASE, 3'd0, 4'd1);    // now it fits
      send_cmd(OP_RELEASE, 3'd0, 4'd0);    // nothing released
      send_cmd(OP_STAGE, 3'd5, 4'd15);     // waits on a full ring
      send_cmd(OP_RELEASE, 3'd6, 4'd15);   // whole ring back, channel 5 goes
      send_cmd(OP_RELEASE, 3'd4, 4'd10);   // partial release of what is left
      wait_drained();

      // back-pressure: receiver stalls for a long stretch while items keep coming
      hold_start  = 1'b1;
      sender_gaps = 1'b0;
      repeat (30) send_random();
      sender_gaps = 1'b1;
      wait_drained();

      // random part, with one full pause midway and a calm tail
      for (int i = 0; i < 400; i++) begin
         if (i == 200) wait_drained();
         if (i == 340) calm = 1'b1;
         send_random();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("%0d items sent, %0d packets dispatched, %0d results flagged rejected",
               items_sent, dispatch_count, reject_count);
      $display("full ring, release saturation, refused stages and a %0d-cycle output stall",
               HOLD_CYCLES);
      if (fail_count == 0)
         $display("[tx_ring_round_robin_dispatch_core] OK");
      else
         $display("[tx_ring_round_robin_dispatch_core] ERROR");
      $finish;
   end

   // Receiver: random stall bursts and ready runs, one long hold when asked.
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_start) begin
            hold_start = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Watchdog, well above the slowest legal run.
   initial begin
      #10000000;
      $display("[tx_ring_round_robin_dispatch_core] ERROR");
      $finish;
   end

endmodule
